// File: sv/tglt_pkg.sv
// Shared types, constants and codes for the terrain grid LOD triangulator.
package tglt_pkg;

  // Page geometry.
  localparam int unsigned PAGE_CELLS = 128;
  localparam int unsigned PAGE_LOG2  = $clog2(PAGE_CELLS);
  localparam int unsigned COORD_W    = PAGE_LOG2 + 1;
  localparam int unsigned CELL_W     = 7;
  localparam int unsigned VERT_W     = 15;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned SH_W       = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned OFF_W      = 4;
  localparam int unsigned CLS_W      = 4;

  // Register reset value, address width and register address.
  localparam logic [STEP_W-1:0] LOD_STEP_RESET = STEP_W'(4);
  localparam int unsigned ADDR_W = 2;
  localparam logic [ADDR_W-1:0] ADDR_LOD_STEP = ADDR_W'(0);

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_STEP = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;

  // Cell classes that select a triangle pattern.
  localparam logic [CLS_W-1:0] CL_QUAD  = 4'd0;
  localparam logic [CLS_W-1:0] CL_TL    = 4'd1;
  localparam logic [CLS_W-1:0] CL_TR    = 4'd2;
  localparam logic [CLS_W-1:0] CL_BL    = 4'd3;
  localparam logic [CLS_W-1:0] CL_BR    = 4'd4;
  localparam logic [CLS_W-1:0] CL_TOP   = 4'd5;
  localparam logic [CLS_W-1:0] CL_BOT   = 4'd6;
  localparam logic [CLS_W-1:0] CL_LEFT  = 4'd7;
  localparam logic [CLS_W-1:0] CL_RIGHT = 4'd8;
  localparam logic [CLS_W-1:0] CL_ERR   = 4'd9;

  // Input transaction payload.
  typedef struct packed {
    logic [CELL_W-1:0] cell_col;
    logic [CELL_W-1:0] cell_row;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
    logic [VERT_W-1:0] vertex_c;
    logic              last_of_cell;
    logic [STAT_W-1:0] status;
  } out_t;

endpackage

// File: sv/tglt_vidx.sv
// Two-stage unit that maps a kept sample position to its raster vertex index.
module tglt_vidx (
  input  logic                        clk,
  input  logic [tglt_pkg::COORD_W-1:0] x,
  input  logic [tglt_pkg::COORD_W-1:0] y,
  input  logic [tglt_pkg::SH_W-1:0]    sh,
  input  logic                        zero,
  output logic [tglt_pkg::VERT_W-1:0]  idx
);
  import tglt_pkg::*;

  logic [COORD_W-1:0] ym1;
  logic [COORD_W-1:0] lat;
  logic [COORD_W-1:0] ymask;
  logic [VERT_W-1:0]  base_nxt;
  logic [COORD_W-1:0] pos_nxt;
  logic [VERT_W-1:0]  base_r;
  logic [COORD_W-1:0] pos_r;
  logic               zero_r;
  logic [VERT_W-1:0]  idx_r;

  // Row base: full top row, then per row either a lattice row or two border samples.
  always_comb begin
    ym1   = y - COORD_W'(1);
    lat   = ym1 >> sh;
    ymask = (COORD_W'(1) << sh) - COORD_W'(1);
    if (y == '0) begin
      base_nxt = '0;
    end else begin
      base_nxt = VERT_W'(PAGE_CELLS + 1)
               + ((VERT_W'(lat) << PAGE_LOG2) >> sh)
               + VERT_W'(lat)
               + (VERT_W'(ym1 - lat) << 1);
    end
    // Position within the row.
    if (y == '0 || y == COORD_W'(PAGE_CELLS) || sh == '0) begin
      pos_nxt = x;
    end else if ((y & ymask) == '0) begin
      pos_nxt = x >> sh;
    end else begin
      pos_nxt = (x == '0) ? COORD_W'(0) : COORD_W'(1);
    end
  end

  // First stage holds base and position, second stage their sum.
  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    pos_r  <= pos_nxt;
    zero_r <= zero;
    idx_r  <= zero_r ? '0 : base_r + VERT_W'(pos_r);
  end

  assign idx = idx_r;

endmodule

// File: sv/terrain_grid_lod_triangulator.sv
// Top level of the terrain grid LOD triangulator: decode, triangle sequencer, index pipeline.
//
//   Channel   Ports                                       Moves
//   input     start, busy, in_data                        one coarse cell per transaction
//   result    out_valid, out_data                         one triangle or error per cycle
//   config    psel, penable, pwrite, paddr, pwdata,       lod_step register at address 0
//             prdata, pready
//
// The sequencer emits one triangle per cycle; a cell has 2 triangles (interior or step
// 1), step+1 triangles (edge), 2*step triangles (corner) or a single error result.
// A new cell is taken in the cycle its predecessor emits its last triangle.
// A cell's first result passes the point stage and the index unit stages to the ports.
// Reset (rst_n low, synchronous) empties the pipeline and sets lod_step to 4.
// Results cannot be held off, so nothing after the sequencer ever stalls.
module terrain_grid_lod_triangulator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  tglt_pkg::in_t                 in_data,
  output logic                          out_valid,
  output tglt_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tglt_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tglt_pkg::*;

  // Configuration register.
  logic [STEP_W-1:0] lod_step_r;

  // Decoded cell held for the sequencer.
  logic               a_valid_r, a_valid_nxt;
  logic [COORD_W-1:0] a_x0_r, a_y0_r;
  logic [SH_W-1:0]    a_sh_r;
  logic [CLS_W-1:0]   a_cls_r;
  logic [STAT_W-1:0]  a_status_r;
  logic [CNT_W-1:0]   a_nm1_r;
  logic [CNT_W-1:0]   k_r, k_nxt;

  // Decode of the incoming cell.
  logic               accept;
  logic               step_ok;
  logic [SH_W-1:0]    dec_sh;
  logic [COORD_W-1:0] dec_cells, dec_x0, dec_y0, dec_s;
  logic               dec_top, dec_bot, dec_left, dec_right;
  logic [CLS_W-1:0]   dec_cls;
  logic [STAT_W-1:0]  dec_status;
  logic [CNT_W-1:0]   dec_nm1;
  logic               seq_last;

  // Triangle corner offsets from the cell origin.
  logic [OFF_W-1:0]   s4, k4;
  logic [OFF_W-1:0]   dxa, dya, dxb, dyb, dxc, dyc;

  // Point stage.
  logic               b_valid_r, b_last_r, b_zero_r;
  logic [STAT_W-1:0]  b_status_r;
  logic [SH_W-1:0]    b_sh_r;
  logic [COORD_W-1:0] b_xa_r, b_ya_r, b_xb_r, b_yb_r, b_xc_r, b_yc_r;

  // Control that travels beside the index units.
  logic               c_valid_r, c_last_r, d_valid_r, d_last_r;
  logic [STAT_W-1:0]  c_status_r, d_status_r;
  logic [VERT_W-1:0]  va, vb, vc;

  // Fan chain point j of a corner cell, as {dx, dy}.
  function automatic logic [2*OFF_W-1:0] chain_pt(input logic [CLS_W-1:0] cls,
                                                   input logic [OFF_W-1:0] j,
                                                   input logic [OFF_W-1:0] s);
    logic lo;
    logic [2*OFF_W-1:0] r;
    lo = (j <= s);
    case (cls)
      CL_TL:   r = lo ? {s - j, OFF_W'(0)} : {OFF_W'(0), j - s};
      CL_TR:   r = lo ? {s, s - j} : {(s << 1) - j, OFF_W'(0)};
      CL_BL:   r = lo ? {OFF_W'(0), j} : {j - s, s};
      CL_BR:   r = lo ? {j, s} : {s, (s << 1) - j};
      default: r = '0;
    endcase
    return r;
  endfunction

  // APB register port; the single register lies at address 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lod_step_r <= LOD_STEP_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_LOD_STEP) begin
      lod_step_r <= pwdata[STEP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LOD_STEP) ? {{(32-STEP_W){1'b0}}, lod_step_r} : 32'd0;

  // Handshake: the held cell frees up in the cycle of its last triangle.
  assign seq_last = (k_r == a_nm1_r);
  assign busy     = a_valid_r && !seq_last;
  assign accept   = start && !busy;

  // Decode step, range and cell class.
  always_comb begin
    step_ok = (lod_step_r == STEP_W'(1)) || (lod_step_r == STEP_W'(2))
           || (lod_step_r == STEP_W'(4));
    case (lod_step_r)
      STEP_W'(2): dec_sh = SH_W'(1);
      STEP_W'(4): dec_sh = SH_W'(2);
      default:    dec_sh = SH_W'(0);
    endcase
    dec_s     = COORD_W'(1) << dec_sh;
    dec_cells = COORD_W'(PAGE_CELLS) >> dec_sh;
    dec_x0    = COORD_W'(in_data.cell_col) << dec_sh;
    dec_y0    = COORD_W'(in_data.cell_row) << dec_sh;
    dec_top   = (dec_y0 == '0);
    dec_bot   = (dec_y0 + dec_s == COORD_W'(PAGE_CELLS));
    dec_left  = (dec_x0 == '0);
    dec_right = (dec_x0 + dec_s == COORD_W'(PAGE_CELLS));
    if (!step_ok) begin
      dec_status = ST_BAD_STEP;
    end else if (COORD_W'(in_data.cell_col) >= dec_cells
              || COORD_W'(in_data.cell_row) >= dec_cells) begin
      dec_status = ST_RANGE;
    end else begin
      dec_status = ST_OK;
    end
    if (dec_status != ST_OK) begin
      dec_cls = CL_ERR;
    end else if (dec_sh == '0 || !(dec_top || dec_bot || dec_left || dec_right)) begin
      dec_cls = CL_QUAD;
    end else if (dec_top && dec_left) begin
      dec_cls = CL_TL;
    end else if (dec_top && dec_right) begin
      dec_cls = CL_TR;
    end else if (dec_bot && dec_left) begin
      dec_cls = CL_BL;
    end else if (dec_bot && dec_right) begin
      dec_cls = CL_BR;
    end else if (dec_top) begin
      dec_cls = CL_TOP;
    end else if (dec_bot) begin
      dec_cls = CL_BOT;
    end else if (dec_left) begin
      dec_cls = CL_LEFT;
    end else begin
      dec_cls = CL_RIGHT;
    end
    // Triangle count minus one.
    case (dec_cls)
      CL_ERR:                       dec_nm1 = CNT_W'(0);
      CL_QUAD:                      dec_nm1 = CNT_W'(1);
      CL_TL, CL_TR, CL_BL, CL_BR:   dec_nm1 = CNT_W'((dec_s << 1) - COORD_W'(1));
      default:                      dec_nm1 = CNT_W'(dec_s);
    endcase
  end

  // Sequencer control.
  always_comb begin
    a_valid_nxt = a_valid_r;
    k_nxt       = k_r;
    if (a_valid_r) begin
      k_nxt = seq_last ? '0 : k_r + CNT_W'(1);
      if (seq_last) begin
        a_valid_nxt = 1'b0;
      end
    end
    if (accept) begin
      a_valid_nxt = 1'b1;
      k_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      k_r       <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      k_r       <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_x0_r     <= dec_x0;
      a_y0_r     <= dec_y0;
      a_sh_r     <= dec_sh;
      a_cls_r    <= dec_cls;
      a_status_r <= dec_status;
      a_nm1_r    <= dec_nm1;
    end
  end

  // Corner offsets of triangle k of the held cell.
  always_comb begin
    s4 = OFF_W'(1) << a_sh_r;
    k4 = OFF_W'(k_r);
    {dxa, dya, dxb, dyb, dxc, dyc} = '0;
    case (a_cls_r)
      CL_QUAD: begin
        if (k_r == '0) begin
          {dxa, dya, dxb, dyb, dxc, dyc} = {OFF_W'(0), OFF_W'(0), OFF_W'(0), s4, s4, OFF_W'(0)};
        end else begin
          {dxa, dya, dxb, dyb, dxc, dyc} = {s4, OFF_W'(0), OFF_W'(0), s4, s4, s4};
        end
      end
      CL_TL, CL_TR, CL_BL, CL_BR: begin
        {dxb, dyb} = chain_pt(a_cls_r, k4, s4);
        {dxc, dyc} = chain_pt(a_cls_r, k4 + OFF_W'(1), s4);
        case (a_cls_r)
          CL_TL:   {dxa, dya} = {s4, s4};
          CL_TR:   {dxa, dya} = {OFF_W'(0), s4};
          CL_BL:   {dxa, dya} = {s4, OFF_W'(0)};
          default: {dxa, dya} = {OFF_W'(0), OFF_W'(0)};
        endcase
      end
      CL_TOP, CL_LEFT: begin
        if (k4 == s4) begin
          {dxa, dya, dxb, dyb, dxc, dyc} = {s4, OFF_W'(0), OFF_W'(0), s4, s4, s4};
        end else if (a_cls_r == CL_TOP) begin
          {dxa, dya, dxb, dyb, dxc, dyc} =
            {OFF_W'(0), s4, k4 + OFF_W'(1), OFF_W'(0), k4, OFF_W'(0)};
        end else begin
          {dxa, dya, dxb, dyb, dxc, dyc} =
            {s4, OFF_W'(0), OFF_W'(0), k4, OFF_W'(0), k4 + OFF_W'(1)};
        end
      end
      CL_BOT, CL_RIGHT: begin
        if (k4 == s4) begin
          {dxa, dya, dxb, dyb, dxc, dyc} =
            {OFF_W'(0), OFF_W'(0), OFF_W'(0), s4, s4, OFF_W'(0)};
        end else if (a_cls_r == CL_BOT) begin
          {dxa, dya, dxb, dyb, dxc, dyc} = {s4, OFF_W'(0), k4, s4, k4 + OFF_W'(1), s4};
        end else begin
          {dxa, dya, dxb, dyb, dxc, dyc} = {OFF_W'(0), s4, s4, k4 + OFF_W'(1), s4, k4};
        end
      end
      default: begin
        {dxa, dya, dxb, dyb, dxc, dyc} = '0;
      end
    endcase
  end

  // Point stage: absolute sample coordinates of the three corners.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_xa_r     <= a_x0_r + COORD_W'(dxa);
    b_ya_r     <= a_y0_r + COORD_W'(dya);
    b_xb_r     <= a_x0_r + COORD_W'(dxb);
    b_yb_r     <= a_y0_r + COORD_W'(dyb);
    b_xc_r     <= a_x0_r + COORD_W'(dxc);
    b_yc_r     <= a_y0_r + COORD_W'(dyc);
    b_sh_r     <= a_sh_r;
    b_last_r   <= seq_last;
    b_status_r <= a_status_r;
    b_zero_r   <= (a_status_r != ST_OK);
  end

  // Vertex index units, one per corner.
  tglt_vidx u_vidx_a (.clk(clk), .x(b_xa_r), .y(b_ya_r), .sh(b_sh_r), .zero(b_zero_r),
                      .idx(va));
  tglt_vidx u_vidx_b (.clk(clk), .x(b_xb_r), .y(b_yb_r), .sh(b_sh_r), .zero(b_zero_r),
                      .idx(vb));
  tglt_vidx u_vidx_c (.clk(clk), .x(b_xc_r), .y(b_yc_r), .sh(b_sh_r), .zero(b_zero_r),
                      .idx(vc));

  // Valid bits and flags matched to the index unit latency.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    c_last_r   <= b_last_r;
    c_status_r <= b_status_r;
    d_last_r   <= c_last_r;
    d_status_r <= c_status_r;
  end

  // Result port.
  assign out_valid             = d_valid_r;
  assign out_data.vertex_a     = va;
  assign out_data.vertex_b     = vb;
  assign out_data.vertex_c     = vc;
  assign out_data.last_of_cell = d_last_r;
  assign out_data.status       = d_status_r;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the terrain grid LOD triangulator.
module tb_top;
  import tglt_pkg::*;

  localparam int unsigned STEP_MAX    = 4;
  localparam int unsigned MAX_TRIS    = 2 * STEP_MAX;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned RAND_CELLS  = 95;
  localparam int unsigned BAD_CELLS   = 6;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        start   = 1'b0;
  in_t         in_data = '0;
  logic        busy;
  logic        out_valid;
  out_t        out_data;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr  = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Scoreboard state: the step the block should be using and the triangles still owed.
  logic [STEP_W-1:0] lod_step_model = LOD_STEP_RESET;
  out_t        pending_tris[$];
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  bit          gaps_on        = 1'b1;

  terrain_grid_lod_triangulator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Raster index of a kept sample; rows off the lattice keep only their two border samples.
  function automatic int unsigned kept_index(int unsigned x, int unsigned y, int unsigned s);
    int unsigned per;
    int unsigned lat;
    int unsigned base;
    int unsigned pos;
    per  = PAGE_CELLS / s + 1;
    base = 0;
    if (y > 0) begin
      lat  = (y - 1) / s;
      base = (PAGE_CELLS + 1) + lat * per + ((y - 1) - lat) * 2;
    end
    if (y == 0 || y == PAGE_CELLS || s == 1) begin
      pos = x;
    end else if (y % s == 0) begin
      pos = x / s;
    end else begin
      pos = (x == 0) ? 0 : 1;
    end
    return base + pos;
  endfunction

  function automatic out_t make_tri(int unsigned a, int unsigned b, int unsigned c);
    out_t t;
    t.vertex_a     = VERT_W'(a);
    t.vertex_b     = VERT_W'(b);
    t.vertex_c     = VERT_W'(c);
    t.last_of_cell = 1'b0;
    t.status       = ST_OK;
    return t;
  endfunction

  function automatic out_t error_tri(logic [STAT_W-1:0] code);
    out_t t;
    t              = '0;
    t.last_of_cell = 1'b1;
    t.status       = code;
    return t;
  endfunction

  // Appends one triangle to the tail of the owed list.
  function automatic void owe_tri(out_t t);
    pending_tris.insert(pending_tris.size(), t);
  endfunction

  // Works out every triangle of one cell at the current step and queues them in order.
  function automatic void predict_cell(in_t c);
    out_t        tris[MAX_TRIS];
    int unsigned chain[MAX_TRIS + 1];
    int unsigned s, cells, cx, cy, x0, y0, x1, y1, tl, tr, bl, br, anchor, len, i;
    int          k, n;
    bit          top, bottom, left, right;
    s  = lod_step_model;
    cx = c.cell_col;
    cy = c.cell_row;
    n  = 0;
    if (!(s == 1 || s == 2 || s == 4)) begin
      owe_tri(error_tri(ST_BAD_STEP));
      return;
    end
    cells = PAGE_CELLS / s;
    if (cx >= cells || cy >= cells) begin
      owe_tri(error_tri(ST_RANGE));
      return;
    end
    x0 = cx * s;
    y0 = cy * s;
    x1 = x0 + s;
    y1 = y0 + s;
    tl = kept_index(x0, y0, s);
    tr = kept_index(x1, y0, s);
    bl = kept_index(x0, y1, s);
    br = kept_index(x1, y1, s);
    top    = (y0 == 0);
    bottom = (y1 == PAGE_CELLS);
    left   = (x0 == 0);
    right  = (x1 == PAGE_CELLS);

    if (s == 1 || (!top && !bottom && !left && !right)) begin
      // Plain quad split along the same diagonal everywhere.
      tris[n] = make_tri(tl, bl, tr); n++;
      tris[n] = make_tri(tr, bl, br); n++;
    end else if ((top || bottom) && (left || right)) begin
      // Corner cell: fan from the opposite corner over both stitched borders.
      len = 0;
      if (top && left) begin
        anchor = br;
        chain[len] = tr; len++;
        for (k = s - 1; k >= 0; k--) begin chain[len] = kept_index(x0 + k, y0, s); len++; end
        for (i = 1; i <= s; i++) begin chain[len] = kept_index(x0, y0 + i, s); len++; end
      end else if (top && right) begin
        anchor = bl;
        chain[len] = br; len++;
        for (k = s - 1; k >= 0; k--) begin chain[len] = kept_index(x1, y0 + k, s); len++; end
        for (k = s - 1; k >= 0; k--) begin chain[len] = kept_index(x0 + k, y0, s); len++; end
      end else if (bottom && left) begin
        anchor = tr;
        chain[len] = tl; len++;
        for (i = 1; i <= s; i++) begin chain[len] = kept_index(x0, y0 + i, s); len++; end
        for (i = 1; i <= s; i++) begin chain[len] = kept_index(x0 + i, y1, s); len++; end
      end else begin
        anchor = tl;
        chain[len] = bl; len++;
        for (i = 1; i <= s; i++) begin chain[len] = kept_index(x0 + i, y1, s); len++; end
        for (k = s - 1; k >= 0; k--) begin chain[len] = kept_index(x1, y0 + k, s); len++; end
      end
      for (i = 0; i + 1 < len; i++) begin
        tris[n] = make_tri(anchor, chain[i], chain[i + 1]);
        n++;
      end
    end else if (top) begin
      for (i = 0; i < s; i++) begin
        tris[n] = make_tri(bl, kept_index(x0 + i + 1, y0, s), kept_index(x0 + i, y0, s));
        n++;
      end
      tris[n] = make_tri(tr, bl, br); n++;
    end else if (bottom) begin
      for (i = 0; i < s; i++) begin
        tris[n] = make_tri(tr, kept_index(x0 + i, y1, s), kept_index(x0 + i + 1, y1, s));
        n++;
      end
      tris[n] = make_tri(tl, bl, tr); n++;
    end else if (left) begin
      for (i = 0; i < s; i++) begin
        tris[n] = make_tri(tr, kept_index(x0, y0 + i, s), kept_index(x0, y0 + i + 1, s));
        n++;
      end
      tris[n] = make_tri(tr, bl, br); n++;
    end else begin
      for (i = 0; i < s; i++) begin
        tris[n] = make_tri(bl, kept_index(x1, y0 + i + 1, s), kept_index(x1, y0 + i, s));
        n++;
      end
      tris[n] = make_tri(tl, bl, tr); n++;
    end

    tris[n - 1].last_of_cell = 1'b1;
    for (k = 0; k < n; k++) owe_tri(tris[k]);
  endfunction

  // Counts a failure and prints it.
  function automatic void flag(string msg);
    mismatch_count++;
    $display("%s", msg);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      flag($sformatf("%0t: %s expected %0d, actual %0d", $time, name, want, got));
  endfunction

  // Result monitor: every strobed triangle must match the oldest one still owed.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_tris.size() == 0) begin
        flag($sformatf("%0t: no triangle expected, actual a=%0d b=%0d c=%0d last=%0b st=%0d",
                       $time, out_data.vertex_a, out_data.vertex_b, out_data.vertex_c,
                       out_data.last_of_cell, out_data.status));
      end else begin
        want = pending_tris.pop_front();
        check_field("vertex_a", 32'(want.vertex_a), 32'(out_data.vertex_a));
        check_field("vertex_b", 32'(want.vertex_b), 32'(out_data.vertex_b));
        check_field("vertex_c", 32'(want.vertex_c), 32'(out_data.vertex_c));
        check_field("last_of_cell", 32'(want.last_of_cell), 32'(out_data.last_of_cell));
        check_field("status", 32'(want.status), 32'(out_data.status));
      end
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Offers one cell, with random gaps before it while gaps_on is set, and predicts it once it is taken.
  task automatic send_cell(input in_t c);
    while (gaps_on && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (busy);
    predict_cell(c);
  endtask

  // Lets every owed triangle arrive, then waits for the pipeline to empty.
  task automatic drain();
    start <= 1'b0;
    while (pending_tris.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic read_step_back();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_LOD_STEP;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[STEP_W-1:0] !== lod_step_model)
      flag($sformatf("%0t: lod_step read expected %0d, actual %0d",
                     $time, lod_step_model, prdata[STEP_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes lod_step once the block is idle; the unused data bits carry noise.
  task automatic set_step(input logic [STEP_W-1:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_LOD_STEP;
    pwdata  <= ($urandom() & ~32'(2 ** STEP_W - 1)) | 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    lod_step_model = v;
    @(posedge clk);
    read_step_back();
  endtask

  function automatic in_t at_cell(int unsigned col, int unsigned row);
    in_t c;
    c.cell_col = CELL_W'(col);
    c.cell_row = CELL_W'(row);
    return c;
  endfunction

  // Mostly in-range cells with a lean toward the border, some anywhere in the field.
  function automatic in_t random_cell();
    int unsigned s, cells, pick;
    in_t         c;
    s     = lod_step_model;
    cells = (s == 1 || s == 2 || s == 4) ? PAGE_CELLS / s : PAGE_CELLS;
    pick  = $urandom_range(99);
    c = at_cell($urandom_range(cells - 1), $urandom_range(cells - 1));
    if (pick < 10) begin
      c = at_cell($urandom_range(127), $urandom_range(127));
    end else if (pick < 25) begin
      c.cell_col = CELL_W'($urandom_range(1) ? cells - 1 : 0);
    end else if (pick < 40) begin
      c.cell_row = CELL_W'($urandom_range(1) ? cells - 1 : 0);
    end else if (pick < 50) begin
      c.cell_col = CELL_W'($urandom_range(1) ? cells - 1 : 0);
      c.cell_row = CELL_W'($urandom_range(1) ? cells - 1 : 0);
    end
    return c;
  endfunction

  // Cells at the reset lod_step: every corner, every edge, the interior and the range limits.
  task automatic test_reset_step_cells();
    read_step_back();
    send_cell(at_cell(0, 0));
    send_cell(at_cell(31, 0));
    send_cell(at_cell(0, 31));
    send_cell(at_cell(31, 31));
    send_cell(at_cell(5, 0));
    send_cell(at_cell(5, 31));
    send_cell(at_cell(0, 7));
    send_cell(at_cell(31, 7));
    send_cell(at_cell(10, 12));
    send_cell(at_cell(32, 0));
    send_cell(at_cell(0, 32));
    send_cell(at_cell(31, 32));
    send_cell(at_cell(127, 127));
  endtask

  // Step 1 never stitches and has no out-of-range cell; step 2 stitches with short runs.
  task automatic test_fine_step_cells();
    set_step(STEP_W'(1));
    send_cell(at_cell(0, 0));
    send_cell(at_cell(127, 127));
    send_cell(at_cell(127, 0));
    send_cell(at_cell(64, 64));
    set_step(STEP_W'(2));
    send_cell(at_cell(0, 0));
    send_cell(at_cell(63, 63));
    send_cell(at_cell(63, 0));
    send_cell(at_cell(0, 63));
    send_cell(at_cell(64, 0));
  endtask

  // A step outside 1, 2 and 4 (here 3, 0 and 7) rejects the cell with a bad-step status.
  task automatic test_unsupported_steps();
    set_step(STEP_W'(3));
    send_cell(at_cell(0, 0));
    set_step(STEP_W'(0));
    send_cell(at_cell(127, 127));
    set_step(STEP_W'(7));
    send_cell(at_cell(5, 9));
  endtask

  // Random cells across every step, one run of them without sender gaps.
  task automatic test_random_cells();
    logic [STEP_W-1:0] bad_steps[5];
    bad_steps = '{STEP_W'(5), STEP_W'(6), STEP_W'(0), STEP_W'(3), STEP_W'(7)};
    set_step(STEP_W'(4));
    repeat (RAND_CELLS) send_cell(random_cell());
    set_step(STEP_W'(2));
    repeat (RAND_CELLS) send_cell(random_cell());
    set_step(STEP_W'(1));
    gaps_on = 1'b0;
    repeat (RAND_CELLS) send_cell(random_cell());
    gaps_on = 1'b1;
    foreach (bad_steps[i]) begin
      set_step(bad_steps[i]);
      repeat (BAD_CELLS) send_cell(random_cell());
    end
    set_step(STEP_W'(4));
    repeat (RAND_CELLS) send_cell(random_cell());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_step_cells();
    test_fine_step_cells();
    test_unsupported_steps();
    test_random_cells();
    drain();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
